// ===== sv/spc_pkg.sv =====
// shared types, constants and helpers for the spa path route classifier
package spc_pkg;

    localparam int MAX_PATH_CHARS_DEF = 256;
    localparam int PREFIX_BYTES_DEF   = 8;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int PFX_LEN_W  = 4;
    localparam int OUT_W      = 3;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_SLASH = 8'h2f;
    localparam logic [7:0] CHR_DOT   = 8'h2e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREFIX_BYTES  = 3'd0,
        CFG_PREFIX_LENGTH = 3'd1,
        CFG_USE_CONTEXT   = 3'd2,
        CFG_SHELL_AVAIL   = 3'd3,
        CFG_CLIENT_SCRIPT = 3'd4,
        CFG_DEGRADED      = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_SHELL    = 2'd0,
        ACT_PASS     = 2'd1,
        ACT_FILE     = 2'd2,
        ACT_FALLBACK = 2'd3
    } t_route_action;

    // path summary handed from the tracker to the decision logic
    typedef struct packed {
        logic is_empty;
        logic lone_slash;
        logic prefix_hit;
        logic has_ext;
    } t_path_flags;

    typedef struct packed {
        logic use_context;
        logic shell_up;
        logic scripts_on;
        logic degraded_mode;
    } t_ctx_cfg;

    // effective prefix length: clamped, then cut at the first zero byte
    function automatic logic [PFX_LEN_W-1:0] prefix_len(
        input logic [CFG_DATA_W-1:0] bytes,
        input logic [PFX_LEN_W-1:0]  len,
        input logic [PFX_LEN_W-1:0]  max_len
    );
        logic [PFX_LEN_W-1:0] lim;
        logic [PFX_LEN_W-1:0] res;
        logic                 found;
        lim   = (len > max_len) ? max_len : len;
        res   = lim;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && (PFX_LEN_W'(i) < lim) && (bytes[8*i +: 8] == CHR_NUL)) begin
                res   = PFX_LEN_W'(i);
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/spc_path_track.sv =====
// per-byte path state: length, prefix match and final segment extension flags
module spc_path_track #(
    parameter int MAX_PATH_CHARS = spc_pkg::MAX_PATH_CHARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_byte,
    input  logic [spc_pkg::CFG_DATA_W-1:0] i_prefix_bytes,
    input  logic [spc_pkg::PFX_LEN_W-1:0]  i_prefix_len,
    output spc_pkg::t_path_flags          o_flags
);
    import spc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATH_CHARS + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic r_match, n_match;
    logic r_first_slash, n_first_slash;
    logic r_seg_start, n_seg_start;
    logic r_dot_seen, n_dot_seen;
    logic r_dot_at_start, n_dot_at_start;
    logic r_after_dot, n_after_dot;

    logic [CNT_W-1:0] pl_ext;
    logic [7:0]       pfx_byte;

    assign pl_ext   = CNT_W'(i_prefix_len);
    assign pfx_byte = i_prefix_bytes[8*r_count[2:0] +: 8];

    always_comb begin
        n_count        = r_count;
        n_match        = r_match;
        n_first_slash  = r_first_slash;
        n_seg_start    = r_seg_start;
        n_dot_seen     = r_dot_seen;
        n_dot_at_start = r_dot_at_start;
        n_after_dot    = r_after_dot;
        if (i_accept) begin
            if (i_byte == CHR_NUL) begin
                // terminator: back to an empty path
                n_count        = '0;
                n_match        = 1'b1;
                n_first_slash  = 1'b0;
                n_seg_start    = 1'b1;
                n_dot_seen     = 1'b0;
                n_dot_at_start = 1'b0;
                n_after_dot    = 1'b0;
            end else if (r_count < CNT_W'(MAX_PATH_CHARS)) begin
                if ((r_count < pl_ext) && (pfx_byte != i_byte)) begin
                    n_match = 1'b0;
                end
                if (r_count == '0) begin
                    n_first_slash = (i_byte == CHR_SLASH);
                end
                if (i_byte == CHR_SLASH) begin
                    n_seg_start    = 1'b1;
                    n_dot_seen     = 1'b0;
                    n_dot_at_start = 1'b0;
                    n_after_dot    = 1'b0;
                end else if (i_byte == CHR_DOT) begin
                    n_dot_seen     = 1'b1;
                    n_dot_at_start = r_seg_start;
                    n_after_dot    = 1'b0;
                    n_seg_start    = 1'b0;
                end else begin
                    if (r_dot_seen) begin
                        n_after_dot = 1'b1;
                    end
                    n_seg_start = 1'b0;
                end
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_match        <= 1'b1;
            r_first_slash  <= 1'b0;
            r_seg_start    <= 1'b1;
            r_dot_seen     <= 1'b0;
            r_dot_at_start <= 1'b0;
            r_after_dot    <= 1'b0;
        end else begin
            r_count        <= n_count;
            r_match        <= n_match;
            r_first_slash  <= n_first_slash;
            r_seg_start    <= n_seg_start;
            r_dot_seen     <= n_dot_seen;
            r_dot_at_start <= n_dot_at_start;
            r_after_dot    <= n_after_dot;
        end
    end

    assign o_flags.is_empty   = (r_count == '0);
    assign o_flags.lone_slash = (r_count == CNT_W'(1)) && r_first_slash;
    assign o_flags.prefix_hit = r_match && (r_count >= pl_ext);
    assign o_flags.has_ext    = r_dot_seen && !r_dot_at_start && r_after_dot;

endmodule

// ===== sv/spc_route_decide.sv =====
// routing decision from the path summary and the context registers
module spc_route_decide (
    input  spc_pkg::t_path_flags          i_flags,
    input  spc_pkg::t_ctx_cfg             i_ctx,
    input  logic [spc_pkg::PFX_LEN_W-1:0] i_prefix_len,
    output logic [spc_pkg::OUT_W-1:0]     o_word
);
    import spc_pkg::*;

    t_route_action act;
    logic          shell_bad;

    assign shell_bad = !i_ctx.shell_up || !i_ctx.scripts_on
                       || i_ctx.degraded_mode;

    always_comb begin
        if (i_flags.is_empty || i_flags.lone_slash) begin
            act = ACT_SHELL;
        end else if (i_ctx.use_context && (i_prefix_len != '0) && i_flags.prefix_hit) begin
            act = ACT_PASS;
        end else if (i_flags.has_ext) begin
            act = ACT_FILE;
        end else begin
            act = ACT_SHELL;
        end
        if (i_ctx.use_context && (act == ACT_SHELL) && shell_bad) begin
            act = ACT_FALLBACK;
        end
    end

    assign o_word = {i_flags.has_ext, act};

endmodule

// ===== sv/spc_out_skid.sv =====
// two-entry output buffer: result register plus skid register
module spc_out_skid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [spc_pkg::OUT_W-1:0]     i_word,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [spc_pkg::OUT_W-1:0]     o_word,
    input  logic                          i_take
);
    import spc_pkg::*;

    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_word, n_out_word;
    logic             r_skid_valid, n_skid_valid;
    logic [OUT_W-1:0] r_skid_word, n_skid_word;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_skid_valid = r_skid_valid;
        n_skid_word  = r_skid_word;
        if (!r_out_valid || i_take) begin
            if (r_skid_valid) begin
                n_out_word   = r_skid_word;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out_word  = i_word;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            // result register stalled: park the word
            n_skid_word  = i_word;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

// ===== sv/spa_path_route_classifier_top.sv =====
// top level of the spa path route classifier
// Takes one path byte per cycle while ready is high; a zero byte ends the path and yields
// one registered routing word, other bytes yield nothing. Per-byte flag updates and
// the final decision sit between the path state registers and a two-entry output
// buffer, so the block sustains one byte per clock and drops ready only when two
// results are waiting downstream. Configuration writes take effect from the next cycle.
module spa_path_route_classifier_top #(
    parameter int MAX_PATH_CHARS = spc_pkg::MAX_PATH_CHARS_DEF,
    parameter int PREFIX_BYTES   = spc_pkg::PREFIX_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] path_byte
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [7:0]                      o_m_tdata,   // [1:0] route_action, [2] has_extension
    input  logic                            i_cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import spc_pkg::*;

    logic [CFG_DATA_W-1:0] r_prefix_bytes;
    logic [PFX_LEN_W-1:0]  r_prefix_length;
    t_ctx_cfg              r_ctx;

    logic [PFX_LEN_W-1:0]  pl;
    logic                  accept;
    logic                  push;
    t_path_flags           flags;
    logic [OUT_W-1:0]      dec_word;
    logic [OUT_W-1:0]      out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_bytes      <= '0;
            r_prefix_length     <= '0;
            r_ctx.use_context   <= 1'b0;
            r_ctx.shell_up      <= 1'b1;
            r_ctx.scripts_on    <= 1'b1;
            r_ctx.degraded_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PREFIX_BYTES:  r_prefix_bytes      <= i_cfg_data;
                CFG_PREFIX_LENGTH: r_prefix_length     <= i_cfg_data[PFX_LEN_W-1:0];
                CFG_USE_CONTEXT:   r_ctx.use_context   <= i_cfg_data[0];
                CFG_SHELL_AVAIL:   r_ctx.shell_up      <= i_cfg_data[0];
                CFG_CLIENT_SCRIPT: r_ctx.scripts_on    <= i_cfg_data[0];
                CFG_DEGRADED:      r_ctx.degraded_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign pl     = prefix_len(r_prefix_bytes, r_prefix_length, PFX_LEN_W'(PREFIX_BYTES));
    assign accept = i_s_tvalid && o_s_tready;
    assign push   = accept && (i_s_tdata == CHR_NUL);

    spc_path_track #(
        .MAX_PATH_CHARS(MAX_PATH_CHARS)
    ) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (i_s_tdata),
        .i_prefix_bytes (r_prefix_bytes),
        .i_prefix_len   (pl),
        .o_flags        (flags)
    );

    spc_route_decide u_decide (
        .i_flags      (flags),
        .i_ctx        (r_ctx),
        .i_prefix_len (pl),
        .o_word       (dec_word)
    );

    spc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (dec_word),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_word  (out_word),
        .i_take  (i_m_tready)
    );

    assign o_m_tdata = {{(8-OUT_W){1'b0}}, out_word};

`ifndef NO_ASSERTIONS
    // input stalls only while both output entries are occupied
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty result register");

    // a new result appears only after an accepted terminator
    a_result_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && (i_s_tdata == CHR_NUL)))
        else $error("result without terminator");

    // ordinary path bytes never create a result
    a_byte_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tdata != CHR_NUL) && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result from non-terminator byte");
`endif

endmodule

// ===== test/spa_path_route_classifier_top_tb.sv =====
// self-checking testbench for the spa path route classifier top level
module spa_path_route_classifier_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam int          PATH_LIMIT   = MAX_PATH_CHARS_DEF;
    localparam int          PFX_MAX      = PREFIX_BYTES_DEF;
    localparam int          NUM_PHASES   = 8;
    localparam int          PHASE_BYTES  = 40;
    localparam int          HOLD_PHASE   = 3;
    localparam int          HOLD_CYCLES  = 80;
    localparam logic [2:0]  CFG_SPARE_LO = 3'd6;
    localparam logic [2:0]  CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        t_route_action act;
        logic          ext;
    } route_t;

    // path classifier model plus the queue of routes still owed by the block
    class route_scoreboard;
        logic [63:0] pfx_bytes;
        logic [3:0]  pfx_len;
        logic        ctx_on;
        logic        shell_ok;
        logic        script_ok;
        logic        degraded;
        int unsigned nchars;
        logic        pfx_match;
        logic        lead_slash;
        logic        seg_start;
        logic        dot_seen;
        logic        dot_lead;
        logic        tail_after_dot;
        route_t      routes_due[$];
        int          errors;
        int          bytes_in;
        int          routes_seen;
        int          act_count[4];

        function new();
            pfx_bytes   = '0;
            pfx_len     = '0;
            ctx_on      = 1'b0;
            shell_ok    = 1'b1;
            script_ok   = 1'b1;
            degraded    = 1'b0;
            errors      = 0;
            bytes_in    = 0;
            routes_seen = 0;
            foreach (act_count[i]) act_count[i] = 0;
            clear_path();
        endfunction

        function void clear_path();
            nchars         = 0;
            pfx_match      = 1'b1;
            lead_slash     = 1'b0;
            seg_start      = 1'b1;
            dot_seen       = 1'b0;
            dot_lead       = 1'b0;
            tail_after_dot = 1'b0;
        endfunction

        function logic [7:0] pfx_char(int unsigned i);
            return pfx_bytes[8*(i%8) +: 8];
        endfunction

        // clamp to the prefix width, then stop at the first zero byte
        function int unsigned eff_prefix_len();
            int unsigned lim;
            lim = (pfx_len > PFX_MAX) ? PFX_MAX : pfx_len;
            for (int unsigned i = 0; i < lim; i++)
                if (pfx_char(i) == CHR_NUL) return i;
            return lim;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                CFG_PREFIX_BYTES:  pfx_bytes = d;
                CFG_PREFIX_LENGTH: pfx_len   = d[3:0];
                CFG_USE_CONTEXT:   ctx_on    = d[0];
                CFG_SHELL_AVAIL:   shell_ok  = d[0];
                CFG_CLIENT_SCRIPT: script_ok = d[0];
                CFG_DEGRADED:      degraded  = d[0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned pl;
            route_t      r;
            logic        ext;
            bytes_in++;
            if (b != CHR_NUL) begin
                // characters past the length limit leave the path state alone
                if (nchars < PATH_LIMIT) begin
                    pl = eff_prefix_len();
                    if (nchars < pl && pfx_char(nchars) != b) pfx_match = 1'b0;
                    if (nchars == 0) lead_slash = (b == CHR_SLASH);
                    if (b == CHR_SLASH) begin
                        seg_start      = 1'b1;
                        dot_seen       = 1'b0;
                        dot_lead       = 1'b0;
                        tail_after_dot = 1'b0;
                    end else if (b == CHR_DOT) begin
                        dot_seen       = 1'b1;
                        dot_lead       = seg_start;
                        tail_after_dot = 1'b0;
                        seg_start      = 1'b0;
                    end else begin
                        if (dot_seen) tail_after_dot = 1'b1;
                        seg_start = 1'b0;
                    end
                    nchars++;
                end
            end else begin
                ext = dot_seen && !dot_lead && tail_after_dot;
                pl  = eff_prefix_len();
                if (nchars == 0 || (nchars == 1 && lead_slash)) begin
                    r.act = ACT_SHELL;
                end else if (ctx_on && pl != 0 && pfx_match && nchars >= pl) begin
                    r.act = ACT_PASS;
                end else if (ext) begin
                    r.act = ACT_FILE;
                end else begin
                    r.act = ACT_SHELL;
                end
                if (ctx_on && r.act == ACT_SHELL && (!shell_ok || !script_ok || degraded))
                    r.act = ACT_FALLBACK;
                r.ext = ext;
                routes_due.push_back(r);
                clear_path();
            end
        endfunction

        function void flag(string what, logic [7:0] want, logic [7:0] got);
            errors++;
            if (errors <= 40)
                $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
        endfunction

        function void check_word(logic [7:0] w);
            route_t want;
            if (routes_due.size() == 0) begin
                flag("unexpected route word (none pending), word", 8'h00, w);
                return;
            end
            want = routes_due.pop_front();
            routes_seen++;
            act_count[want.act]++;
            if (w[1:0] !== want.act) flag("route_action", 8'(want.act), 8'(w[1:0]));
            if (w[2] !== want.ext)   flag("has_extension", 8'(want.ext), 8'(w[2]));
            if (w[7:3] !== 5'd0)     flag("tdata padding", 8'h00, 8'(w[7:3]));
        endfunction

        function int pending();
            return routes_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    route_scoreboard sb = new();
    logic [7:0]      path_q[$];
    bit              calm     = 1'b0;
    bit              hold_req = 1'b0;
    bit              hold_on  = 1'b0;
    int              gap_pct  = 0;
    int              settings = 0;

    spa_path_route_classifier_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // [7:0] path_byte
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),    // [1:0] route_action, [2] has_extension
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // all tb drives are nonblocking, so these reads see pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_byte(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_word(o_m_tdata);
            if (i_cfg_we) sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // receiver: random stall bursts, one long hold on request, none at the end
    initial begin
        forever begin
            if (hold_req) begin
                hold_on = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on  = 1'b0;
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return CHR_SLASH;
        if (r < 35) return CHR_DOT;
        if (r < 80) return 8'(8'h61 + $urandom_range(0, 3));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_byte(logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_path();
        foreach (path_q[i]) send_byte(path_q[i]);
        send_byte(CHR_NUL);
    endtask

    task automatic send_text(string s);
        path_q.delete();
        for (int i = 0; i < s.len(); i++) path_q.push_back(s[i]);
        send_path();
    endtask

    // stop sending and let every owed route come out
    task automatic drain();
        i_s_tvalid <= 1'b0;
        // let the monitor log the last accepted word first
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [63:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
    endtask

    task automatic configure(int p);
        logic [63:0] pfx;
        logic [3:0]  len;
        logic        ctx;
        logic        sh;
        logic        sc;
        logic        dg;
        case (p)
            0: begin
                pfx = '1; len = 4'hf; ctx = 1'b1; sh = 1'b0; sc = 1'b0; dg = 1'b1;
            end
            1: begin
                pfx = '0; len = 4'h0; ctx = 1'b0; sh = 1'b1; sc = 1'b1; dg = 1'b0;
            end
            2: begin
                // "/ap" then a zero byte, so only three characters count
                pfx = 64'h7878_7878_0070_612f; len = 4'h8;
                ctx = 1'b1; sh = 1'b1; sc = 1'b1; dg = 1'b0;
            end
            default: begin
                len = 4'($urandom_range(0, 15));
                for (int i = 0; i < 8; i++)
                    pfx[8*i +: 8] = ($urandom_range(0, 9) == 0) ? CHR_NUL : pick_char();
                ctx = ($urandom_range(0, 3) != 0);
                sh  = ($urandom_range(0, 3) != 0);
                sc  = ($urandom_range(0, 3) != 0);
                dg  = ($urandom_range(0, 3) == 0);
            end
        endcase
        // unused upper data bits carry noise
        set_reg(CFG_PREFIX_BYTES,  pfx);
        set_reg(CFG_PREFIX_LENGTH, {$urandom, 15'($urandom_range(0, 15'h7fff)), 13'h0, len});
        set_reg(CFG_USE_CONTEXT,   {$urandom, $urandom} & ~64'h1 | 64'(ctx));
        set_reg(CFG_SHELL_AVAIL,   {$urandom, $urandom} & ~64'h1 | 64'(sh));
        set_reg(CFG_CLIENT_SCRIPT, {$urandom, $urandom} & ~64'h1 | 64'(sc));
        set_reg(CFG_DEGRADED,      {$urandom, $urandom} & ~64'h1 | 64'(dg));
        set_reg(CFG_SPARE_LO,      {$urandom, $urandom});
        set_reg(CFG_SPARE_HI,      {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // prefix-led paths (just under half), some cut short or with one bit flipped, rest free form
    task automatic build_path(bit long_one);
        int unsigned pl;
        int          kind;
        int          k;
        int          n;
        int          pos;
        path_q.delete();
        pl   = sb.eff_prefix_len();
        kind = $urandom_range(0, 99);
        k    = 0;
        if (pl != 0 && kind < 45) begin
            k = (kind >= 30 && kind < 38) ? $urandom_range(0, pl - 1) : pl;
            for (int i = 0; i < k; i++) path_q.push_back(sb.pfx_char(i));
            if (kind >= 38 && k > 0) begin
                pos = $urandom_range(0, k - 1);
                path_q[pos] = path_q[pos] ^ (8'h01 << $urandom_range(0, 7));
                if (path_q[pos] == CHR_NUL) path_q[pos] = 8'h80;
            end
        end
        if (long_one)
            n = $urandom_range(PATH_LIMIT - 6, PATH_LIMIT + 14);
        else if (pl != 0 && kind >= 30 && kind < 38)
            n = 0;
        else
            n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) path_q.push_back(pick_char());
    endtask

    initial begin
        int sent;
        int choice;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, no context
        send_text("");
        send_text("/");
        send_text("/x.js");
        send_text("/.h");
        send_text("a.");
        drain();
        set_reg(CFG_PREFIX_BYTES,  64'h612f);
        set_reg(CFG_PREFIX_LENGTH, 64'd2);
        set_reg(CFG_USE_CONTEXT,   64'd1);
        set_reg(CFG_DEGRADED,      64'd1);
        i_cfg_we <= 1'b0;
        settings++;
        send_text("/a");
        send_text("/a.b");
        send_text("/");

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            configure(p);
            if (p == NUM_PHASES - 1) calm = 1'b1;
            if (p == HOLD_PHASE) begin
                // keep offering short paths while the receiver is held off
                hold_req = 1'b1;
                while (!hold_on) @(posedge i_clk);
                gap_pct = 0;
                repeat (24) send_text("k");
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                choice  = $urandom_range(0, 2);
                gap_pct = (choice == 0) ? 0 : (choice == 1) ? 10 : 35;
                build_path((p == 2 || p == 5) && sent == 0);
                send_path();
                sent += path_q.size() + 1;
            end
        end
        drain();
        repeat (10) @(posedge i_clk);

        $display("checked %0d routes from %0d path bytes over %0d register settings",
                 sb.routes_seen, sb.bytes_in, settings);
        $display("routes by action: shell %0d, api %0d, file %0d, fallback %0d",
                 sb.act_count[ACT_SHELL], sb.act_count[ACT_PASS],
                 sb.act_count[ACT_FILE], sb.act_count[ACT_FALLBACK]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS spa_path_route_classifier_top");
        end else begin
            $display("FAIL spa_path_route_classifier_top");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL spa_path_route_classifier_top");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/spc_pkg.sv
sv/spc_path_track.sv
sv/spc_route_decide.sv
sv/spc_out_skid.sv
sv/spa_path_route_classifier_top.sv
test/spa_path_route_classifier_top_tb.sv
